// ===== rtl/core/sv39_page_table_walker_assert.svh =====
// Assertion macros for the Sv39 page-table walker.
// Used by the top level only; relies on aclk and aresetn being in scope.
`ifndef SV39_PAGE_TABLE_WALKER_ASSERT_SVH
`define SV39_PAGE_TABLE_WALKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SV39_PTW_ASSERT_NOW(label, antecedent, consequent, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (antecedent) |-> (consequent)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SV39_PTW_ASSERT_NEXT(label, antecedent, consequent, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (antecedent) |=> (consequent)) else $error(msg);

`endif

// ===== rtl/core/sv39_ptw_pkg.sv =====
// Shared types, constants and helper functions of the Sv39 page-table walker.
// No dependencies; the front, queue, back and top-level files refer to it by scoped names.
package sv39_ptw_pkg;

    // Page-table geometry.
    localparam int LEVELS           = 3;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int VPN_W            = 9;
    localparam int LEVEL_W          = 2;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(LEVELS - 1);
    localparam int PG_SHIFT         = 12;
    localparam int PGSIZE           = 4096;
    localparam int VA_BITS          = 38;   // addresses at or above 2^38 are rejected
    localparam int WALK_VA_W        = 39;   // bits that the three slices and offset span

    // Entry layout.
    localparam int PTE_V_BIT = 0;
    localparam int PTE_U_BIT = 4;
    localparam int PPN_LSB   = 10;
    localparam int PPN_MSB   = 53;
    localparam int PPN_W     = PPN_MSB - PPN_LSB + 1;
    localparam int PA_W      = 56;

    // Item field widths.
    localparam int WORD_INDEX_W = 13;
    localparam int DATA_W       = 64;
    localparam int STATUS_W     = 3;
    localparam int ROOT_W       = 4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UPPER    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LEAF     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_USER = 3'd4;

    // Input commands.
    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    // Configuration register map.
    localparam int   APB_ADDR_W    = 3;
    localparam int   APB_DATA_W    = 32;
    localparam logic REG_ROOT_PAGE = 1'b0;
    localparam logic REG_USER_MODE = 1'b1;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // What the back part has to do with a queued item.
    typedef enum logic [1:0] {
        OP_WRITE,   // store one table word, then report success
        OP_WALK,    // three-level walk
        OP_DONE     // result already known; report the carried status
    } op_kind_t;

    typedef struct packed {
        op_kind_t                  kind;
        logic [STATUS_W-1:0]       status;
        logic [WORD_INDEX_W-1:0]   word_index;
        logic [DATA_W-1:0]         data;    // word_data for writes, virt_addr for walks
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

    // Virtual page number slice used at a given level.
    function automatic logic [VPN_W-1:0] vpn_slice(input logic [WALK_VA_W-1:0] va,
                                                   input logic [LEVEL_W-1:0]   level);
        logic [VPN_W-1:0] slice;
        unique case (level)
            2'd2:    slice = va[38:30];
            2'd1:    slice = va[29:21];
            default: slice = va[20:12];
        endcase
        return slice;
    endfunction

endpackage

// ===== rtl/core/sv39_page_table_walker.sv =====
// Sv39 page-table walker: input channel (s_*) takes table-word writes and
// translation requests; result channel (m_*) returns one status and physical
// address per transfer, in order. Configuration (root page, user mode) sits on
// an APB-style port at byte addresses 0 and 4 and is changed only while idle, a
// rule on the user that the block itself does not enforce. A transfer lands in
// a two-entry queue; the back part reads one item a cycle while it is free to
// take it. Writes and translations that fault before any table read pass from
// the queue to the result register. A translation that reaches the leaf needs
// one synchronous table read per level before the result register is loaded;
// a new translation starts only as the current walk finishes, while writes
// sustain one per cycle when the receiver is ready. The single read port of
// the table store sets the translation rate. A stalled receiver holds the
// result register; the queue keeps accepting until it is full, then s_ready
// falls. Reset clears control state and the configuration registers (root
// page 0, user mode 1); the table store is not cleared, so every entry must be written before a walk reads it.
// Depends on sv39_ptw_pkg, sv39_ptw_front, sv39_ptw_queue and sv39_ptw_back.
`include "sv39_page_table_walker_assert.svh"

module sv39_page_table_walker #(
    parameter int TABLE_PAGES = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Input channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_cmd,
    input  logic [sv39_ptw_pkg::WORD_INDEX_W-1:0]   s_word_index,
    input  logic [sv39_ptw_pkg::DATA_W-1:0]         s_word_data,
    input  logic [sv39_ptw_pkg::DATA_W-1:0]         s_virt_addr,
    // Result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [sv39_ptw_pkg::STATUS_W-1:0]       m_status,
    output logic [sv39_ptw_pkg::PA_W-1:0]           m_phys_addr,
    // Configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [sv39_ptw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sv39_ptw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sv39_ptw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);

    logic [sv39_ptw_pkg::ROOT_W-1:0] root_page_reg;
    logic                            user_mode_reg;
    logic                            cfg_write;
    logic                            reg_sel;

    logic                            push;
    logic                            pop;
    sv39_ptw_pkg::queue_entry_t      push_entry;
    sv39_ptw_pkg::queue_entry_t      head_entry;
    sv39_ptw_pkg::queue_flags_t      q_flags;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_page_reg <= '0;
            user_mode_reg <= 1'b1;
        end else if (cfg_write) begin
            unique case (reg_sel)
                sv39_ptw_pkg::REG_ROOT_PAGE: root_page_reg <= pwdata[sv39_ptw_pkg::ROOT_W-1:0];
                sv39_ptw_pkg::REG_USER_MODE: user_mode_reg <= pwdata[0];
                default:                     user_mode_reg <= user_mode_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_sel)
            sv39_ptw_pkg::REG_ROOT_PAGE: prdata = sv39_ptw_pkg::APB_DATA_W'(root_page_reg);
            sv39_ptw_pkg::REG_USER_MODE: prdata = sv39_ptw_pkg::APB_DATA_W'(user_mode_reg);
            default:                     prdata = '0;
        endcase
    end

    // Front part: acceptance and classification.
    sv39_ptw_front #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_word_index  (s_word_index),
        .s_word_data   (s_word_data),
        .s_virt_addr   (s_virt_addr),
        .cfg_root_page (root_page_reg),
        .q_flags       (q_flags),
        .push          (push),
        .push_entry    (push_entry)
    );

    // Queue between the two parts.
    sv39_ptw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_flags    (q_flags)
    );

    // Back part: table store, walker and result register.
    sv39_ptw_back #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_entry    (head_entry),
        .q_flags       (q_flags),
        .pop           (pop),
        .cfg_root_page (root_page_reg),
        .cfg_user_mode (user_mode_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_phys_addr   (m_phys_addr)
    );

    // A faulting result never carries an address.
    `SV39_PTW_ASSERT_NOW(a_fault_zero_addr, m_valid && (m_status != sv39_ptw_pkg::ST_OK), m_phys_addr == '0, "fault result carries a non-zero address")
    // In user mode a successful result is page-aligned.
    `SV39_PTW_ASSERT_NOW(a_user_page_aligned, m_valid && user_mode_reg && (m_status == sv39_ptw_pkg::ST_OK), m_phys_addr[sv39_ptw_pkg::PG_SHIFT-1:0] == '0, "user-mode result not page-aligned")
    // The user-bit fault cannot arise in kernel mode.
    `SV39_PTW_ASSERT_NOW(a_no_user_fault_kernel, m_valid && !user_mode_reg, m_status != sv39_ptw_pkg::ST_NOT_USER, "user-bit fault reported in kernel mode")
    // A root page write takes effect on the next cycle.
    `SV39_PTW_ASSERT_NEXT(a_root_page_written, cfg_write && (reg_sel == sv39_ptw_pkg::REG_ROOT_PAGE), root_page_reg == $past(pwdata[3:0]), "root page register not updated by write")

endmodule

// ===== rtl/core/sv39_ptw_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module sv39_ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds while re is low.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sv39_ptw_front.sv =====
// Front part: takes input transfers and classifies them for the back part.
// Depends on sv39_ptw_pkg.
module sv39_ptw_front #(
    parameter int TABLE_PAGES = 16
) (
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_cmd,
    input  logic [sv39_ptw_pkg::WORD_INDEX_W-1:0]  s_word_index,
    input  logic [sv39_ptw_pkg::DATA_W-1:0]        s_word_data,
    input  logic [sv39_ptw_pkg::DATA_W-1:0]        s_virt_addr,
    input  logic [sv39_ptw_pkg::ROOT_W-1:0]        cfg_root_page,
    input  sv39_ptw_pkg::queue_flags_t             q_flags,
    output logic                                   push,
    output sv39_ptw_pkg::queue_entry_t             push_entry
);

    localparam int STORE_WORDS = TABLE_PAGES * sv39_ptw_pkg::ENTRIES_PER_PAGE;

    logic index_in_store;
    logic va_too_high;
    logic root_in_store;

    assign s_ready = !q_flags.full;
    assign push    = s_valid && s_ready;

    assign index_in_store = 32'(s_word_index) < STORE_WORDS;
    assign va_too_high    = s_virt_addr[sv39_ptw_pkg::DATA_W-1:sv39_ptw_pkg::VA_BITS] != '0;
    assign root_in_store  = 32'(cfg_root_page) < TABLE_PAGES;

    // Early classification: out-of-range writes and translations that fault before
    // any table read are resolved here and only reported by the back part.
    always_comb begin
        push_entry.word_index = s_word_index;
        push_entry.status     = sv39_ptw_pkg::ST_OK;
        push_entry.kind       = sv39_ptw_pkg::OP_DONE;
        push_entry.data       = s_word_data;
        if (s_cmd == sv39_ptw_pkg::CMD_WRITE) begin
            if (index_in_store) begin
                push_entry.kind = sv39_ptw_pkg::OP_WRITE;
            end
        end else begin
            push_entry.data = s_virt_addr;
            priority if (va_too_high) begin
                push_entry.status = sv39_ptw_pkg::ST_RANGE;
            end else if (!root_in_store) begin
                push_entry.status = sv39_ptw_pkg::ST_UPPER;
            end else begin
                push_entry.kind = sv39_ptw_pkg::OP_WALK;
            end
        end
    end

endmodule

// ===== rtl/core/sv39_ptw_queue.sv =====
// Short first-in first-out queue of classified items between front and back.
// Depends on sv39_ptw_pkg.
module sv39_ptw_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  sv39_ptw_pkg::queue_entry_t  push_entry,
    input  logic                        pop,
    output sv39_ptw_pkg::queue_entry_t  head_entry,
    output sv39_ptw_pkg::queue_flags_t  q_flags
);

    localparam int DEPTH   = sv39_ptw_pkg::QUEUE_DEPTH;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    sv39_ptw_pkg::queue_entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg,  count_next;

    // Pointer and fill-level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry    = entries_reg[rd_ptr_reg];
    assign q_flags.full  = count_reg == COUNT_W'(DEPTH);
    assign q_flags.empty = count_reg == '0;

endmodule

// ===== rtl/core/sv39_ptw_back.sv =====
// Back part: owns the table store, performs writes and three-level walks,
// and holds the result register. Depends on sv39_ptw_pkg and sv39_ptw_ram.
module sv39_ptw_back #(
    parameter int TABLE_PAGES = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sv39_ptw_pkg::queue_entry_t          head_entry,
    input  sv39_ptw_pkg::queue_flags_t          q_flags,
    output logic                                pop,
    input  logic [sv39_ptw_pkg::ROOT_W-1:0]     cfg_root_page,
    input  logic                                cfg_user_mode,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sv39_ptw_pkg::STATUS_W-1:0]   m_status,
    output logic [sv39_ptw_pkg::PA_W-1:0]       m_phys_addr
);

    localparam int STORE_WORDS = TABLE_PAGES * sv39_ptw_pkg::ENTRIES_PER_PAGE;
    localparam int AW          = $clog2(STORE_WORDS);
    localparam int PW          = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int LW          = sv39_ptw_pkg::LEVEL_W;
    localparam int VW          = sv39_ptw_pkg::WALK_VA_W;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t                              state_reg,      state_next;
    logic [LW-1:0]                       level_reg,      level_next;
    logic [VW-1:0]                       va_reg,         va_next;
    logic                                out_valid_reg,  out_valid_next;
    logic [sv39_ptw_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [sv39_ptw_pkg::PA_W-1:0]       out_pa_reg,     out_pa_next;

    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    logic [sv39_ptw_pkg::DATA_W-1:0]     ram_wdata;
    logic                                ram_re;
    logic [AW-1:0]                       ram_raddr;
    logic [sv39_ptw_pkg::DATA_W-1:0]     ram_rdata;

    logic                                out_free;
    logic                                head_valid;
    logic                                finish;
    logic [sv39_ptw_pkg::STATUS_W-1:0]   fin_status;
    logic [sv39_ptw_pkg::PA_W-1:0]       fin_pa;
    logic [sv39_ptw_pkg::PPN_W-1:0]      pte_ppn;
    logic                                may_start_walk;
    logic                                may_start_other;

    // Table store.
    sv39_ptw_ram #(
        .WIDTH (sv39_ptw_pkg::DATA_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_valid_reg || m_ready;
    assign head_valid = !q_flags.empty;
    assign pte_ppn    = ram_rdata[sv39_ptw_pkg::PPN_MSB:sv39_ptw_pkg::PPN_LSB];
    assign ram_waddr  = AW'(head_entry.word_index);
    assign ram_wdata  = head_entry.data;

    // Examine the entry returned for the current level.
    always_comb begin
        finish     = 1'b0;
        fin_status = sv39_ptw_pkg::ST_OK;
        fin_pa     = '0;
        if (state_reg == S_WALK) begin
            priority if (!ram_rdata[sv39_ptw_pkg::PTE_V_BIT]) begin
                finish     = 1'b1;
                fin_status = (level_reg != '0) ? sv39_ptw_pkg::ST_UPPER
                                               : sv39_ptw_pkg::ST_LEAF;
            end else if (level_reg != '0) begin
                if (pte_ppn >= sv39_ptw_pkg::PPN_W'(TABLE_PAGES)) begin
                    finish     = 1'b1;
                    fin_status = sv39_ptw_pkg::ST_UPPER;
                end
            end else if (cfg_user_mode && !ram_rdata[sv39_ptw_pkg::PTE_U_BIT]) begin
                finish     = 1'b1;
                fin_status = sv39_ptw_pkg::ST_NOT_USER;
            end else begin
                finish = 1'b1;
                fin_pa = cfg_user_mode ? {pte_ppn, sv39_ptw_pkg::PG_SHIFT'(0)}
                                       : {pte_ppn, va_reg[sv39_ptw_pkg::PG_SHIFT-1:0]};
            end
        end
    end

    // A walk may start whenever the walker is idle, or is finishing this cycle with a free result
    // register; a write or an early result needs an idle walker and a free result register.
    assign may_start_walk  = (state_reg == S_IDLE) || (finish && out_free);
    assign may_start_other = (state_reg == S_IDLE) && out_free;

    // Next-state logic for the walker and the result register.
    always_comb begin
        state_next      = state_reg;
        level_next      = level_reg;
        va_next         = va_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_pa_next     = out_pa_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        // Follow a valid pointer to the next level.
        if (state_reg == S_WALK && !finish) begin
            ram_re     = 1'b1;
            ram_raddr  = AW'({PW'(pte_ppn),
                              sv39_ptw_pkg::vpn_slice(va_reg, level_reg - 1'b1)});
            level_next = level_reg - 1'b1;
        end

        // Hand the finished walk to the result register.
        if (finish && out_free) begin
            out_valid_next  = 1'b1;
            out_status_next = fin_status;
            out_pa_next     = fin_pa;
            state_next      = S_IDLE;
        end

        // Take the next item from the queue.
        if (head_valid) begin
            unique case (head_entry.kind)
                sv39_ptw_pkg::OP_WALK: begin
                    if (may_start_walk) begin
                        pop        = 1'b1;
                        ram_re     = 1'b1;
                        ram_raddr  = AW'({PW'(cfg_root_page),
                                          sv39_ptw_pkg::vpn_slice(head_entry.data[VW-1:0],
                                                                  sv39_ptw_pkg::LEVEL_TOP)});
                        va_next    = head_entry.data[VW-1:0];
                        level_next = sv39_ptw_pkg::LEVEL_TOP;
                        state_next = S_WALK;
                    end
                end
                sv39_ptw_pkg::OP_WRITE: begin
                    if (may_start_other) begin
                        pop             = 1'b1;
                        ram_we          = 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = sv39_ptw_pkg::ST_OK;
                        out_pa_next     = '0;
                    end
                end
                sv39_ptw_pkg::OP_DONE: begin
                    if (may_start_other) begin
                        pop             = 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = head_entry.status;
                        out_pa_next     = '0;
                    end
                end
                default: begin
                    pop = 1'b0;
                end
            endcase
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        level_reg      <= level_next;
        va_reg         <= va_next;
        out_status_reg <= out_status_next;
        out_pa_reg     <= out_pa_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = out_status_reg;
    assign m_phys_addr = out_pa_reg;

endmodule

// ===== test/sv39_page_table_walker_checker.sv =====
// Scoreboard for the Sv39 page-table walker testbench: watches the input, result
// and register ports, predicts every result and compares it in order.
// Depends on sv39_ptw_pkg only.
`timescale 1ns / 1ps

module sv39_page_table_walker_checker #(
    parameter int TABLE_PAGES = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic                                    s_cmd,
    input  logic [sv39_ptw_pkg::WORD_INDEX_W-1:0]   s_word_index,
    input  logic [sv39_ptw_pkg::DATA_W-1:0]         s_word_data,
    input  logic [sv39_ptw_pkg::DATA_W-1:0]         s_virt_addr,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic [sv39_ptw_pkg::STATUS_W-1:0]       m_status,
    input  logic [sv39_ptw_pkg::PA_W-1:0]           m_phys_addr,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [sv39_ptw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sv39_ptw_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [sv39_ptw_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                                    pready,
    output int                                      fail_count,
    output int                                      outstanding,
    output int                                      ok_count,
    output int                                      fault_count
);
    import sv39_ptw_pkg::*;

    localparam int STORE_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;
    localparam logic [APB_ADDR_W-1:0] ADDR_ROOT_PAGE = {REG_ROOT_PAGE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_USER_MODE = {REG_USER_MODE, 2'b00};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PA_W-1:0]     phys_addr;
    } walk_result_t;

    walk_result_t      expected_results[$];
    logic [DATA_W-1:0] table_copy [STORE_WORDS];
    logic [ROOT_W-1:0] root_page = '0;
    logic              user_mode = 1'b1;
    int                errors    = 0;
    int                n_ok      = 0;
    int                n_fault   = 0;

    // Walks levels 2, 1 and 0 over the local copy of the table store.
    function automatic walk_result_t predict_walk(input logic [DATA_W-1:0] va);
        walk_result_t      res;
        logic [PPN_W-1:0]  page;
        logic [DATA_W-1:0] pte;
        int                idx;
        res.status    = ST_OK;
        res.phys_addr = '0;
        pte           = '0;
        if (va >= (64'd1 << VA_BITS)) begin
            res.status = ST_RANGE;
            return res;
        end
        page = PPN_W'(root_page);
        for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
            // A pointer past the end of the store faults before any read.
            if (page >= PPN_W'(TABLE_PAGES)) begin
                res.status = ST_UPPER;
                return res;
            end
            idx = int'(page) * ENTRIES_PER_PAGE
                + int'((va >> (PG_SHIFT + VPN_W * lvl)) & 64'h1FF);
            pte = table_copy[idx];
            if (!pte[PTE_V_BIT]) begin
                res.status = (lvl > 0) ? ST_UPPER : ST_LEAF;
                return res;
            end
            page = pte[PPN_MSB:PPN_LSB];
        end
        // User mode demands the U bit and returns the page base only.
        if (user_mode) begin
            if (!pte[PTE_U_BIT])
                res.status = ST_NOT_USER;
            else
                res.phys_addr = {pte[PPN_MSB:PPN_LSB], {PG_SHIFT{1'b0}}};
        end else begin
            res.phys_addr = {pte[PPN_MSB:PPN_LSB], va[PG_SHIFT-1:0]};
        end
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        walk_result_t          want;
        logic [APB_DATA_W-1:0] reg_value;
        if (!aresetn) begin
            expected_results.delete();
            root_page = '0;
            user_mode = 1'b1;
        end else begin
            // Register port: track writes, check read data.
            if (psel && penable && pready) begin
                reg_value = (paddr == ADDR_ROOT_PAGE) ? APB_DATA_W'(root_page)
                                                      : APB_DATA_W'(user_mode);
                if (pwrite) begin
                    if (paddr == ADDR_ROOT_PAGE)
                        root_page = pwdata[ROOT_W-1:0];
                    else if (paddr == ADDR_USER_MODE)
                        user_mode = pwdata[0];
                end else if (prdata !== reg_value) begin
                    $error("prdata at 0x%0h: expected 0x%0h, got 0x%0h",
                           paddr, reg_value, prdata);
                    errors++;
                end
            end

            // Input transfer: update the store copy or predict a walk.
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_WRITE) begin
                    if (int'(s_word_index) < STORE_WORDS)
                        table_copy[s_word_index] = s_word_data;
                    want.status    = ST_OK;
                    want.phys_addr = '0;
                end else begin
                    want = predict_walk(s_virt_addr);
                end
                expected_results.push_back(want);
            end

            // Result transfer: compare with the oldest expectation.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer (status %0d, address 0x%0h) with none expected",
                           m_status, m_phys_addr);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("m_status: expected %0d, got %0d", want.status, m_status);
                        errors++;
                    end
                    if (m_phys_addr !== want.phys_addr) begin
                        $error("m_phys_addr: expected 0x%0h, got 0x%0h",
                               want.phys_addr, m_phys_addr);
                        errors++;
                    end
                end
                if (m_status == ST_OK)
                    n_ok++;
                else
                    n_fault++;
            end
        end
        fail_count  <= errors;
        outstanding <= expected_results.size();
        ok_count    <= n_ok;
        fault_count <= n_fault;
    end

endmodule

// ===== test/sv39_page_table_walker_tb.sv =====
// Top of the Sv39 page-table walker testbench: clock, reset, stimulus on the
// input and register ports, receiver stalls and the final verdict.
// Depends on sv39_ptw_pkg, sv39_page_table_walker and its checker module.
`timescale 1ns / 1ps

module sv39_page_table_walker_tb;
    import sv39_ptw_pkg::*;

    localparam int TABLE_PAGES     = 16;
    localparam int STORE_WORDS     = TABLE_PAGES * ENTRIES_PER_PAGE;
    localparam int RESET_CYCLES    = 7;
    localparam int PHASES          = 8;
    localparam int RANDOM_ITEMS    = 1030;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 300000;
    localparam logic [APB_ADDR_W-1:0] ADDR_ROOT_PAGE = {REG_ROOT_PAGE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_USER_MODE = {REG_USER_MODE, 2'b00};

    logic                    aclk         = 1'b0;
    logic                    aresetn      = 1'b0;
    logic                    s_valid      = 1'b0;
    logic                    s_cmd        = CMD_WRITE;
    logic [WORD_INDEX_W-1:0] s_word_index = '0;
    logic [DATA_W-1:0]       s_word_data  = '0;
    logic [DATA_W-1:0]       s_virt_addr  = '0;
    logic                    m_ready      = 1'b0;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr        = '0;
    logic [APB_DATA_W-1:0]   pwdata       = '0;
    logic                    s_ready;
    logic                    m_valid;
    logic [STATUS_W-1:0]     m_status;
    logic [PA_W-1:0]         m_phys_addr;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    int fail_count;
    int outstanding;
    int ok_count;
    int fault_count;

    // Stimulus state: a shadow of the store so that no walk reads a word
    // that was never written.
    logic [DATA_W-1:0] shadow_word [STORE_WORDS];
    bit                shadow_written [STORE_WORDS];
    logic [ROOT_W-1:0] cur_root   = '0;
    logic [DATA_W-1:0] recent_vas[$];
    int                gap_pct    = 0;
    int                stall_pct  = 0;
    bit                hold_arm   = 1'b0;
    int                hold_count = 0;
    int                cycle_count = 0;
    int                n_writes   = 0;
    int                n_walks    = 0;
    int                n_settings = 0;

    sv39_page_table_walker #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_word_index (s_word_index),
        .s_word_data  (s_word_data),
        .s_virt_addr  (s_virt_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_phys_addr  (m_phys_addr),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    sv39_page_table_walker_checker #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_word_index (s_word_index),
        .s_word_data  (s_word_data),
        .s_virt_addr  (s_virt_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_phys_addr  (m_phys_addr),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .ok_count     (ok_count),
        .fault_count  (fault_count)
    );

    // Clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver: one long hold-off once armed, random stalls otherwise.
    always @(posedge aclk) begin
        if (hold_arm && hold_count < HOLD_OFF_CYCLES) begin
            hold_count <= hold_count + 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Pointer entry to a table page; some are broken when break_pct is non-zero.
    function automatic logic [DATA_W-1:0] upper_entry(input int page, input int break_pct);
        logic [DATA_W-1:0] pte;
        int                pick;
        pte                     = rand64();
        pte[PTE_V_BIT]          = 1'b1;
        pte[PPN_MSB:PPN_LSB]    = PPN_W'(page);
        pick                    = $urandom_range(99);
        if (pick < break_pct / 2)
            pte[PTE_V_BIT] = 1'b0;
        else if (pick < break_pct)
            pte[PPN_LSB + $clog2(TABLE_PAGES)
                + $urandom_range(PPN_W - $clog2(TABLE_PAGES) - 1)] = 1'b1;
        return pte;
    endfunction

    // Leaf entry: mostly valid, mostly user-accessible, random page number.
    function automatic logic [DATA_W-1:0] leaf_entry();
        logic [DATA_W-1:0] pte;
        pte            = rand64();
        pte[PTE_V_BIT] = ($urandom_range(9) != 0);
        pte[PTE_U_BIT] = ($urandom_range(9) < 7);
        return pte;
    endfunction

    // True when a walk of va touches only store words already written.
    function automatic bit walk_is_safe(input logic [DATA_W-1:0] va);
        logic [PPN_W-1:0]  page;
        logic [DATA_W-1:0] pte;
        int                idx;
        if (va >= (64'd1 << VA_BITS))
            return 1'b1;
        page = PPN_W'(cur_root);
        for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
            if (page >= PPN_W'(TABLE_PAGES))
                return 1'b1;
            idx = int'(page) * ENTRIES_PER_PAGE + int'(va[PG_SHIFT + VPN_W * lvl +: VPN_W]);
            if (!shadow_written[idx])
                return 1'b0;
            pte = shadow_word[idx];
            if (!pte[PTE_V_BIT])
                return 1'b1;
            page = pte[PPN_MSB:PPN_LSB];
        end
        return 1'b1;
    endfunction

    // One input transfer, after a random gap of idle cycles.
    task automatic send_item(input logic cmd, input logic [WORD_INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] data, input logic [DATA_W-1:0] va);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < gap_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_word_index <= idx;
        s_word_data  <= data;
        s_virt_addr  <= va;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (cmd == CMD_WRITE) begin
            shadow_word[idx]    = data;
            shadow_written[idx] = 1'b1;
            n_writes++;
        end else begin
            n_walks++;
        end
    endtask

    task automatic write_word(input logic [WORD_INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
        send_item(CMD_WRITE, idx, data, rand64());
    endtask

    task automatic walk_va(input logic [DATA_W-1:0] va);
        send_item(CMD_TRANSLATE, WORD_INDEX_W'($urandom), rand64(), va);
    endtask

    // A walk that would read an unwritten word is pushed out of range instead.
    task automatic walk_safe(input logic [DATA_W-1:0] va);
        if (!walk_is_safe(va))
            va[VA_BITS + $urandom_range(DATA_W - VA_BITS - 1)] = 1'b1;
        walk_va(va);
    endtask

    // Stop offering, then wait until every expected result has arrived.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register access: setup cycle, access cycle, then psel and penable drop.
    task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [ROOT_W-1:0] root, input logic user);
        apb_access(1'b1, ADDR_ROOT_PAGE, APB_DATA_W'(root));
        apb_access(1'b1, ADDR_USER_MODE, APB_DATA_W'(user));
        apb_access(1'b0, ADDR_ROOT_PAGE, '0);
        apb_access(1'b0, ADDR_USER_MODE, '0);
        cur_root = root;
        n_settings++;
    endtask

    // Mapping: three table writes, with some entries broken at random, then walks through it.
    task automatic build_mapping();
        logic [VPN_W-1:0]  vpn2;
        logic [VPN_W-1:0]  vpn1;
        logic [VPN_W-1:0]  vpn0;
        int                next1;
        int                next0;
        logic [DATA_W-1:0] va;
        vpn2  = VPN_W'($urandom_range(255));
        vpn1  = VPN_W'($urandom);
        vpn0  = VPN_W'($urandom);
        next1 = $urandom_range(TABLE_PAGES - 1);
        next0 = $urandom_range(TABLE_PAGES - 1);
        write_word(WORD_INDEX_W'(int'(cur_root) * ENTRIES_PER_PAGE + int'(vpn2)),
                   upper_entry(next1, 15));
        write_word(WORD_INDEX_W'(next1 * ENTRIES_PER_PAGE + int'(vpn1)), upper_entry(next0, 15));
        write_word(WORD_INDEX_W'(next0 * ENTRIES_PER_PAGE + int'(vpn0)), leaf_entry());
        va = {25'd0, vpn2, vpn1, vpn0, 12'd0};
        recent_vas.push_back(va);
        if (recent_vas.size() > 32)
            void'(recent_vas.pop_front());
        repeat ($urandom_range(3, 1)) begin
            va[PG_SHIFT-1:0] = PG_SHIFT'($urandom);
            walk_safe(va);
        end
    endtask

    initial begin : stimulus
        int                phase;
        int                target;
        int                pick;
        logic [DATA_W-1:0] va;
        logic [DATA_W-1:0] pte;
        logic [ROOT_W-1:0] root;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers come out of reset as root page 0, user mode on.
        apb_access(1'b0, ADDR_ROOT_PAGE, '0);
        apb_access(1'b0, ADDR_USER_MODE, '0);

        // Directed: a chain down the top corner of the address space.
        write_word(13'd255, upper_entry(1, 0));
        write_word(13'd1023, upper_entry(2, 0));
        write_word(13'd1535, {10'h3FF, {PPN_W{1'b1}}, 10'h011});
        walk_va((64'd1 << VA_BITS) - 64'd1);
        // Lowest and highest out-of-range addresses.
        walk_va(64'd1 << VA_BITS);
        walk_va('1);
        // Leaf without the user bit.
        pte            = rand64();
        pte[PTE_V_BIT] = 1'b1;
        pte[PTE_U_BIT] = 1'b0;
        write_word(13'd1534, pte);
        walk_va({25'd0, 9'h0FF, 9'h1FF, 9'h1FE, 12'hABC});
        // Invalid leaf.
        pte            = rand64();
        pte[PTE_V_BIT] = 1'b0;
        write_word(13'd1024, pte);
        walk_va({25'd0, 9'h0FF, 9'h1FF, 9'h000, 12'hFFF});
        // Invalid top-level entry.
        write_word(13'd0, 64'd0);
        walk_va(64'd0);
        // Top-level pointer one page past the store.
        write_word(13'd1, upper_entry(TABLE_PAGES, 0));
        walk_va({25'd0, 9'h001, 9'h155, 9'h0AA, 12'h555});
        // Middle pointer with a huge page number, then an invalid middle entry.
        pte          = upper_entry(1, 0);
        pte[PPN_MSB] = 1'b1;
        write_word(13'd512, pte);
        walk_va({25'd0, 9'h0FF, 9'h000, 9'h123, 12'h000});
        write_word(13'd513, 64'd0);
        walk_va({25'd0, 9'h0FF, 9'h001, 9'h000, 12'h001});
        // Last and second-to-last store words, all ones and all zeros.
        write_word(WORD_INDEX_W'(STORE_WORDS - 1), '1);
        write_word(WORD_INDEX_W'(STORE_WORDS - 2), '0);

        // Random phases, each with its own register setting and idling mix.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            recent_vas.delete();
            if (phase == 0 || phase == PHASES - 1)
                root = {ROOT_W{1'b1}};
            else if (phase == 1)
                root = '0;
            else
                root = ROOT_W'($urandom);
            set_config(root, phase % 2 == 1);
            case (phase % 4)
                0: begin
                    gap_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    gap_pct = 80;
                    stall_pct <= 0;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct <= 80;
                end
                default: begin
                    gap_pct = 29;
                    stall_pct <= 29;
                end
            endcase
            // Long receiver hold-off while the sender keeps offering.
            if (phase == 4)
                hold_arm <= 1'b1;

            target = n_writes + n_walks + RANDOM_ITEMS / PHASES;
            while (n_writes + n_walks < target) begin
                pick = $urandom_range(99);
                if (pick < 50 || (pick < 75 && recent_vas.size() == 0)) begin
                    build_mapping();
                end else if (pick < 75) begin
                    va = recent_vas[$urandom_range(recent_vas.size() - 1)];
                    va[PG_SHIFT-1:0] = PG_SHIFT'($urandom);
                    walk_safe(va);
                end else if (pick < 87) begin
                    write_word(WORD_INDEX_W'($urandom), rand64());
                end else if (pick < 94) begin
                    walk_safe(rand64() & ((64'd1 << VA_BITS) - 64'd1));
                end else begin
                    walk_safe(rand64());
                end
                // Now and then the sender pauses until the block has drained.
                if ($urandom_range(149) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        $display("Covered %0d table writes and %0d translations across %0d register settings.",
                 n_writes, n_walks, n_settings);
        $display("Result transfers by status: %0d ok, %0d faulted.", ok_count, fault_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sv39_ptw_pkg.sv
rtl/core/sv39_ptw_ram.sv
rtl/core/sv39_ptw_front.sv
rtl/core/sv39_ptw_queue.sv
rtl/core/sv39_ptw_back.sv
rtl/core/sv39_page_table_walker.sv
test/sv39_page_table_walker_checker.sv
test/sv39_page_table_walker_tb.sv
